// ----- design/jsu_pkg.sv -----
// Shared widths, word types and the command format for the JSON string unescaper.
package jsu_pkg;

  // Width of the per-string output byte counter (saturating).
  localparam int COUNT_WIDTH = 16;
  // Width of the out_length field.
  localparam int LEN_WIDTH   = 16;

  // Byte slots in one command: up to four UTF-8 bytes plus one plain byte.
  localparam int SLOT_COUNT  = 5;
  localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT + 1);

  // Command queue between front and back.
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  // Status codes carried on the done word.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BSL_END = 2'd1;
  localparam logic [1:0] ST_BAD_ESC = 2'd2;
  localparam logic [1:0] ST_BAD_HEX = 2'd3;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 string_done;
    logic [1:0]           status;
    logic [LEN_WIDTH-1:0] out_length;
  } out_t;

  // One classified input word: the bytes it emits, in order, then an
  // optional end-of-string word.
  typedef struct packed {
    logic [SLOT_COUNT-1:0][7:0] bytes;
    logic [SLOT_IDX_W-1:0]      n_bytes;
    logic                       done;
    logic [1:0]                 status;
  } cmd_t;

endpackage

// ----- design/json_string_unescape_utf8_top.sv -----
// Top level of the streaming JSON string unescaper with UTF-8 output.
//
// Feed the escaped body of a JSON string one input word per cycle on in_*;
// each word carries at most one byte, and a word with end_of_string set
// closes the string (has_byte low with end_of_string high closes an empty
// one). Output words on out_* carry the unescaped text as UTF-8, one byte
// per word with byte_valid set, followed by one word with string_done set
// that carries the status (0 ok, 1 backslash at end, 2 bad escape character,
// 3 bad or truncated unicode escape) and the saturating byte count of the
// string. After an error the rest of that string is dropped. Timing: the
// front end takes one input word every cycle while the four-entry command
// queue has room; the back end emits one output word per cycle while
// out_ready allows it, so an input word costs one output word per byte it
// expands to (up to four, for a surrogate pair or for a held high surrogate
// flushed ahead of a plain byte or simple escape) plus one for the done word.
// in_ready drops only when the queue is full, which happens when that
// expansion outpaces the output side or when out_ready is held low. With the
// output side idle, the first output word of an accepted input word is
// registered first in the command queue, at acceptance, and then in the output
// register, which loads from the queue head. The parser state is cleared by
// reset and again after every done word.
module json_string_unescape_utf8_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jsu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output jsu_pkg::out_t out_data
);

  // Classified commands from the parser into the queue.
  logic          cmd_push;
  jsu_pkg::cmd_t cmd;
  logic          cmd_full;

  // Queue head as seen by the emitter.
  jsu_pkg::cmd_t head;
  logic          empty;
  logic          pop;

  // Parse escapes, hold surrogates, classify each word into a command.
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd),
    .cmd_full (cmd_full)
  );

  // Decouple the two sides so a multi-byte escape does not stall input.
  jsu_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (cmd_full)
  );

  // Advance through each command's bytes, then the done word; count bytes.
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/jsu_front.sv -----
// Front end: parses escaped input bytes and queues output commands.
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jsu_pkg::in_t  in_data,
  output logic          cmd_push,
  output jsu_pkg::cmd_t cmd,
  input  logic          cmd_full
);

  typedef enum logic [6:0] {
    M_TEXT = 7'b0000001,
    M_BSL  = 7'b0000010,
    M_HEX  = 7'b0000100,
    M_PEND = 7'b0001000,
    M_PBSL = 7'b0010000,
    M_PU   = 7'b0100000,
    M_ERR  = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {ok, byte}
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_QUOTE, CH_BSL, CH_SLASH: r = {1'b1, c};
      CH_B:                       r = {1'b1, 8'h08};
      CH_F:                       r = {1'b1, 8'h0C};
      CH_N:                       r = {1'b1, 8'h0A};
      CH_R:                       r = {1'b1, 8'h0D};
      CH_T:                       r = {1'b1, 8'h09};
      default:                    r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n    = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  mode_t       mode_r, mode_nxt;
  logic [15:0] fu_r, fu_nxt;
  logic [15:0] su_r, su_nxt;
  logic [1:0]  hc_r, hc_nxt;
  logic [1:0]  ec_r, ec_nxt;

  logic        accept;
  logic [7:0]  c;
  logic [4:0]  hv;
  logic [8:0]  se;
  logic        u_en;
  logic [20:0] cp;
  logic        b_en;
  logic [7:0]  bv;
  logic        dn;
  logic [1:0]  st;
  logic [10:0] pair_hi;
  enc_t        enc;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;
  assign c        = in_data.in_byte;
  assign hv       = hex_val(c);
  assign se       = simple_escape(c);
  // 0x10000 + (hi << 10) + lo: add 0x40 above the low ten bits
  assign pair_hi  = {1'b0, fu_r[9:0]} + 11'h040;

  always_comb begin
    mode_nxt = mode_r;
    fu_nxt   = fu_r;
    su_nxt   = su_r;
    hc_nxt   = hc_r;
    ec_nxt   = ec_r;
    u_en     = 1'b0;
    cp       = '0;
    b_en     = 1'b0;
    bv       = '0;
    dn       = 1'b0;
    st       = jsu_pkg::ST_OK;

    if (in_data.has_byte) begin
      unique case (mode_r)
        M_TEXT: begin
          if (c == CH_BSL) begin
            mode_nxt = M_BSL;
          end else begin
            b_en = 1'b1;
            bv   = c;
          end
        end
        M_BSL: begin
          if (c == CH_U) begin
            fu_nxt   = '0;
            hc_nxt   = '0;
            mode_nxt = M_HEX;
          end else if (se[8]) begin
            b_en     = 1'b1;
            bv       = se[7:0];
            mode_nxt = M_TEXT;
          end else begin
            ec_nxt   = jsu_pkg::ST_BAD_ESC;
            mode_nxt = M_ERR;
          end
        end
        M_HEX: begin
          if (!hv[4]) begin
            ec_nxt   = jsu_pkg::ST_BAD_HEX;
            mode_nxt = M_ERR;
          end else begin
            fu_nxt = {fu_r[11:0], hv[3:0]};
            if (hc_r == 2'd3) begin
              hc_nxt = '0;
              if (fu_nxt[15:10] == 6'b110110) begin
                mode_nxt = M_PEND;
              end else begin
                u_en     = 1'b1;
                cp       = {5'd0, fu_nxt};
                mode_nxt = M_TEXT;
              end
            end else begin
              hc_nxt = hc_r + 2'd1;
            end
          end
        end
        M_PEND: begin
          if (c == CH_BSL) begin
            mode_nxt = M_PBSL;
          end else begin
            u_en     = 1'b1;
            cp       = {5'd0, fu_r};
            b_en     = 1'b1;
            bv       = c;
            mode_nxt = M_TEXT;
          end
        end
        M_PBSL: begin
          if (c == CH_U) begin
            su_nxt   = '0;
            hc_nxt   = '0;
            mode_nxt = M_PU;
          end else begin
            u_en = 1'b1;
            cp   = {5'd0, fu_r};
            if (se[8]) begin
              b_en     = 1'b1;
              bv       = se[7:0];
              mode_nxt = M_TEXT;
            end else begin
              ec_nxt   = jsu_pkg::ST_BAD_ESC;
              mode_nxt = M_ERR;
            end
          end
        end
        M_PU: begin
          if (!hv[4]) begin
            u_en     = 1'b1;
            cp       = {5'd0, fu_r};
            ec_nxt   = jsu_pkg::ST_BAD_HEX;
            mode_nxt = M_ERR;
          end else begin
            su_nxt = {su_r[11:0], hv[3:0]};
            if ((hc_r == 2'd0 && hv[3:0] != 4'hD) || (hc_r == 2'd1 && hv[3:0] < 4'hC)) begin
              // not a low surrogate: emit the held unit, restart as a plain escape
              u_en     = 1'b1;
              cp       = {5'd0, fu_r};
              fu_nxt   = su_nxt;
              hc_nxt   = hc_r + 2'd1;
              mode_nxt = M_HEX;
            end else if (hc_r == 2'd3) begin
              u_en     = 1'b1;
              cp       = {pair_hi[10:0], su_nxt[9:0]};
              hc_nxt   = '0;
              mode_nxt = M_TEXT;
            end else begin
              hc_nxt = hc_r + 2'd1;
            end
          end
        end
        M_ERR: begin
        end
        default: begin
          mode_nxt = M_ERR;
        end
      endcase
    end

    if (in_data.end_of_string) begin
      dn = 1'b1;
      unique case (mode_nxt)
        M_TEXT: st = jsu_pkg::ST_OK;
        M_BSL:  st = jsu_pkg::ST_BSL_END;
        M_HEX:  st = jsu_pkg::ST_BAD_HEX;
        M_PEND: begin
          u_en = 1'b1;
          cp   = {5'd0, fu_nxt};
          st   = jsu_pkg::ST_OK;
        end
        M_PBSL: begin
          u_en = 1'b1;
          cp   = {5'd0, fu_nxt};
          st   = jsu_pkg::ST_BSL_END;
        end
        M_PU: begin
          u_en = 1'b1;
          cp   = {5'd0, fu_nxt};
          st   = jsu_pkg::ST_BAD_HEX;
        end
        default: st = ec_nxt;
      endcase
      mode_nxt = M_TEXT;
      fu_nxt   = '0;
      su_nxt   = '0;
      hc_nxt   = '0;
      ec_nxt   = '0;
    end
  end

  assign enc = utf8_encode(cp);

  always_comb begin
    cmd = '0;
    if (u_en) begin
      for (int i = 0; i < 4; i++) begin
        cmd.bytes[i] = enc.b[i];
      end
    end
    if (b_en) begin
      if (u_en) begin
        cmd.bytes[enc.n] = bv;
      end else begin
        cmd.bytes[0] = bv;
      end
    end
    cmd.n_bytes = (u_en ? jsu_pkg::SLOT_IDX_W'(enc.n) : '0) + jsu_pkg::SLOT_IDX_W'(b_en);
    cmd.done    = dn;
    cmd.status  = st;
  end

  assign cmd_push = accept && (u_en || b_en || dn);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_TEXT;
      fu_r   <= '0;
      su_r   <= '0;
      hc_r   <= '0;
      ec_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      fu_r   <= fu_nxt;
      su_r   <= su_nxt;
      hc_r   <= hc_nxt;
      ec_r   <= ec_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eos_clears_parser: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.end_of_string |=> mode_r == M_TEXT && hc_r == 2'd0 && ec_r == 2'd0)
    else $error("parser state not cleared after end of string");

  a_cmd_fits_slots: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> cmd.n_bytes <= jsu_pkg::SLOT_IDX_W'(jsu_pkg::SLOT_COUNT))
    else $error("command holds more bytes than slots");
`endif

endmodule

// ----- design/jsu_cmd_fifo.sv -----
// Short command queue between the parsing front end and the byte emitter.
module jsu_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t push_data,
  input  logic          pop,
  output jsu_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  jsu_pkg::cmd_t                  mem_r [jsu_pkg::FIFO_DEPTH];
  logic [jsu_pkg::FIFO_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [jsu_pkg::FIFO_AW:0]      count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (jsu_pkg::FIFO_AW+1)'(jsu_pkg::FIFO_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("command queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("command queue overflow");
`endif

endmodule

// ----- design/jsu_back.sv -----
// Back end: expands queued commands into output words and keeps the length count.
module jsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  jsu_pkg::cmd_t  head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output jsu_pkg::out_t  out_data
);

  logic [jsu_pkg::SLOT_IDX_W-1:0]  idx_r, idx_nxt;
  logic [jsu_pkg::COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                            out_valid_r;
  jsu_pkg::out_t                   out_data_r, word;

  logic                            load;
  logic                            is_byte;
  logic                            last;
  logic [jsu_pkg::SLOT_IDX_W-1:0]  words;
  logic [jsu_pkg::COUNT_WIDTH+jsu_pkg::LEN_WIDTH-1:0] cnt_ext;

  assign load    = !empty && (!out_valid_r || out_ready);
  assign is_byte = idx_r < head.n_bytes;
  assign words   = head.n_bytes + jsu_pkg::SLOT_IDX_W'(head.done);
  assign last    = (idx_r + 1'b1) == words;
  assign pop     = load && last;
  assign cnt_ext = {{jsu_pkg::LEN_WIDTH{1'b0}}, cnt_r};

  always_comb begin
    word    = '0;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (is_byte) begin
      word.out_byte   = head.bytes[idx_r];
      word.byte_valid = 1'b1;
    end else begin
      word.string_done = 1'b1;
      word.status      = head.status;
      word.out_length  = cnt_ext[jsu_pkg::LEN_WIDTH-1:0];
    end
    if (load) begin
      idx_nxt = last ? '0 : idx_r + 1'b1;
      if (!is_byte) begin
        cnt_nxt = '0;
      end else if (cnt_r != {jsu_pkg::COUNT_WIDTH{1'b1}}) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_done_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    load && !is_byte |=> cnt_r == '0 && idx_r == '0)
    else $error("length count or slot index not cleared after done word");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    load && is_byte |=> cnt_r >= $past(cnt_r) && cnt_r != '0)
    else $error("length count lost a byte");
`endif

endmodule

// ----- bench/utf8_unescape_checker.sv -----
// Checker for the JSON string unescaper: predicts UTF-8 output words and compares them.
`timescale 1ns / 100ps

module utf8_unescape_checker
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_t        in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_t       out_data,
  output int         mismatch_count,
  output int         words_pending,
  output int         words_checked,
  output int         strings_checked,
  output logic [3:0] status_seen
);

  typedef enum logic [6:0] {
    PM_TEXT     = 7'b0000001,  // plain text
    PM_ESC      = 7'b0000010,  // after a backslash
    PM_HEX      = 7'b0000100,  // collecting \u digits
    PM_HELD     = 7'b0001000,  // high surrogate held, waiting for a possible low one
    PM_HELD_ESC = 7'b0010000,  // high surrogate held, backslash seen
    PM_LOW_HEX  = 7'b0100000,  // high surrogate held, collecting second \u digits
    PM_DROP     = 7'b1000000   // error seen, drop until end of string
  } parse_mode_t;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_U   = "u";

  parse_mode_t            mode;
  logic [15:0]            hi_unit;
  logic [15:0]            lo_unit;
  logic [1:0]             digit_idx;
  logic [1:0]             err_status;
  logic [COUNT_WIDTH-1:0] emitted_len;

  out_t utf8_expected [$];

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic int escape_byte(input logic [7:0] c);
    case (c)
      8'h22, 8'h5C, 8'h2F: return int'(c);
      "b": return 8'h08;
      "f": return 8'h0C;
      "n": return 8'h0A;
      "r": return 8'h0D;
      "t": return 8'h09;
      default: return -1;
    endcase
  endfunction

  task automatic clear_parser();
    mode        = PM_TEXT;
    hi_unit     = '0;
    lo_unit     = '0;
    digit_idx   = '0;
    err_status  = ST_OK;
    emitted_len = '0;
  endtask

  task automatic emit_byte(input logic [7:0] b);
    out_t w;
    w            = '0;
    w.out_byte   = b;
    w.byte_valid = 1'b1;
    utf8_expected.push_back(w);
    if (emitted_len != '1) emitted_len = emitted_len + 1'b1;
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit_byte({3'b110, cp[10:6]});
      emit_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit_byte({4'b1110, cp[15:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end else begin
      emit_byte({5'b11110, cp[20:18]});
      emit_byte({2'b10, cp[17:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic set_error(input logic [1:0] code);
    err_status = code;
    mode       = PM_DROP;
  endtask

  task automatic take_byte(input logic [7:0] c);
    int v;
    case (mode)
      PM_TEXT: begin
        if (c == CH_BSL) mode = PM_ESC;
        else emit_byte(c);
      end
      PM_ESC: begin
        v = escape_byte(c);
        if (c == CH_U) begin
          hi_unit   = '0;
          digit_idx = '0;
          mode      = PM_HEX;
        end else if (v >= 0) begin
          emit_byte(v[7:0]);
          mode = PM_TEXT;
        end else begin
          set_error(ST_BAD_ESC);
        end
      end
      PM_HEX: begin
        v = hex_value(c);
        if (v < 0) begin
          set_error(ST_BAD_HEX);
        end else begin
          hi_unit = {hi_unit[11:0], v[3:0]};
          if (digit_idx == 2'd3) begin
            digit_idx = '0;
            // hold a high surrogate until we know whether a low one follows
            if (hi_unit >= 16'hD800 && hi_unit <= 16'hDBFF) begin
              mode = PM_HELD;
            end else begin
              emit_code_point(21'(hi_unit));
              mode = PM_TEXT;
            end
          end else begin
            digit_idx = digit_idx + 1'b1;
          end
        end
      end
      PM_HELD: begin
        if (c == CH_BSL) begin
          mode = PM_HELD_ESC;
        end else begin
          emit_code_point(21'(hi_unit));
          emit_byte(c);
          mode = PM_TEXT;
        end
      end
      PM_HELD_ESC: begin
        if (c == CH_U) begin
          lo_unit   = '0;
          digit_idx = '0;
          mode      = PM_LOW_HEX;
        end else begin
          emit_code_point(21'(hi_unit));
          v = escape_byte(c);
          if (v >= 0) begin
            emit_byte(v[7:0]);
            mode = PM_TEXT;
          end else begin
            set_error(ST_BAD_ESC);
          end
        end
      end
      PM_LOW_HEX: begin
        v = hex_value(c);
        if (v < 0) begin
          emit_code_point(21'(hi_unit));
          set_error(ST_BAD_HEX);
        end else begin
          lo_unit = {lo_unit[11:0], v[3:0]};
          if ((digit_idx == 2'd0 && v != 'hD) || (digit_idx == 2'd1 && v < 'hC)) begin
            // not a low surrogate: flush the held unit, go on as a plain \u escape
            emit_code_point(21'(hi_unit));
            hi_unit   = lo_unit;
            digit_idx = digit_idx + 1'b1;
            mode      = PM_HEX;
          end else if (digit_idx == 2'd3) begin
            emit_code_point(21'h10000 + {1'b0, hi_unit[9:0], 10'b0} + 21'(lo_unit[9:0]));
            digit_idx = '0;
            mode      = PM_TEXT;
          end else begin
            digit_idx = digit_idx + 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic unescape_word(input in_t w);
    logic [1:0] st;
    out_t       d;
    if (w.has_byte) take_byte(w.in_byte);
    if (w.end_of_string) begin
      case (mode)
        PM_TEXT:     st = ST_OK;
        PM_ESC:      st = ST_BSL_END;
        PM_HEX:      st = ST_BAD_HEX;
        PM_HELD: begin
          emit_code_point(21'(hi_unit));
          st = ST_OK;
        end
        PM_HELD_ESC: begin
          emit_code_point(21'(hi_unit));
          st = ST_BSL_END;
        end
        PM_LOW_HEX: begin
          emit_code_point(21'(hi_unit));
          st = ST_BAD_HEX;
        end
        default:     st = err_status;
      endcase
      d             = '0;
      d.string_done = 1'b1;
      d.status      = st;
      d.out_length  = LEN_WIDTH'(emitted_len);
      utf8_expected.push_back(d);
      clear_parser();
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_word(input out_t got);
    out_t want;
    if (utf8_expected.size() == 0) begin
      $error("output word with nothing expected: out_byte 0x%0h string_done %0b",
             got.out_byte, got.string_done);
      mismatch_count++;
      return;
    end
    want = utf8_expected.pop_front();
    check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
    check_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
    check_field("string_done", 16'(want.string_done), 16'(got.string_done));
    check_field("status", 16'(want.status), 16'(got.status));
    check_field("out_length", 16'(want.out_length), 16'(got.out_length));
    words_checked++;
    if (got.string_done) begin
      strings_checked++;
      status_seen[got.status] = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      utf8_expected.delete();
      mismatch_count  = 0;
      words_checked   = 0;
      strings_checked = 0;
      status_seen     = '0;
    end else begin
      if (in_valid && in_ready) unescape_word(in_data);
      if (out_valid && out_ready) compare_word(out_data);
    end
    words_pending = utf8_expected.size();
  end

endmodule

// ----- bench/tb_json_string_unescape_utf8_top.sv -----
// Testbench top for the JSON string unescaper: stimulus, handshake pressure and verdict.
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8_top;
  import jsu_pkg::*;

  // Close a string on its last byte, or with a separate byte-less end word.
  localparam int CLOSE_ON_LAST  = 0;
  localparam int CLOSE_SEPARATE = 1;

  localparam int IDLE_PCT      = 13;
  localparam int TOTAL_WORDS   = 450;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  // Watchdog limit; keep a wide margin.
  localparam int MAX_CYCLES    = 200000;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_U   = "u";

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int         mismatch_count;
  int         words_pending;
  int         words_checked;
  int         strings_checked;
  logic [3:0] status_seen;

  // Sender and receiver controls: quiet means no random idling at all.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  // Raised once by the stimulus; the receiver clears it and holds off.
  bit hold_req = 1'b0;

  int cycle_count = 0;
  int words_sent  = 0;

  // Escaped body of the string being built.
  logic [7:0] body_q [$];

  // Simple escape letters: quote, backslash, slash, b f n r t.
  logic [7:0] escape_letters [0:7] = '{8'h22, 8'h5C, 8'h2F, "b", "f", "n", "r", "t"};

  always #1 clk = ~clk;

  json_string_unescape_utf8_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  utf8_unescape_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .words_pending   (words_pending),
    .words_checked   (words_checked),
    .strings_checked (strings_checked),
    .status_seen     (status_seen)
  );

  // Watchdog: end the run as failed if it never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: drop ready at random, or hold it low for a long stretch on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        // count the stretch here, independent of the sender
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= rx_quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offer one word, idling first at random; hold it until accepted.
  // Enter and leave just after a falling edge.
  task automatic send_word(input in_t w);
    while (!tx_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (w.has_byte || w.end_of_string) words_sent++;
  endtask

  // Send body_q as one string, with an occasional do-nothing word mixed in.
  task automatic send_body(input int close_how);
    in_t w;
    for (int i = 0; i < body_q.size(); i++) begin
      if ($urandom_range(0, 99) < 3) begin
        w.has_byte      = 1'b0;
        w.in_byte       = 8'($urandom_range(0, 255));
        w.end_of_string = 1'b0;
        send_word(w);
      end
      w.has_byte      = 1'b1;
      w.in_byte       = body_q[i];
      w.end_of_string = (close_how == CLOSE_ON_LAST) && (i == body_q.size() - 1);
      send_word(w);
    end
    if (close_how == CLOSE_SEPARATE || body_q.size() == 0) begin
      w.has_byte      = 1'b0;
      w.in_byte       = 8'($urandom_range(0, 255));
      w.end_of_string = 1'b1;
      send_word(w);
    end
  endtask

  task automatic send_text(input string s, input int close_how);
    body_q.delete();
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    send_body(close_how);
  endtask

  // Drop valid and wait until every predicted output word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
  endtask

  // Hex digit in random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  task automatic push_unicode(input logic [15:0] u);
    body_q.push_back(CH_BSL);
    body_q.push_back(CH_U);
    for (int i = 3; i >= 0; i--) body_q.push_back(hex_char(u[i*4 +: 4]));
  endtask

  // Build a random escaped body: mostly well-formed escapes and text with random
  // content, plus some broken escapes and truncated endings.
  task automatic build_random_body();
    int         segs;
    int         pick;
    logic [7:0] b;
    bit         stop;
    body_q.delete();
    stop = 1'b0;
    segs = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
    for (int s = 0; s < segs && !stop; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        b = 8'($urandom_range(0, 255));
        // keep stray backslashes rare so most strings stay well formed
        if (b == CH_BSL && $urandom_range(0, 9) != 0) b = "a";
        body_q.push_back(b);
      end else if (pick < 50) begin
        body_q.push_back(CH_BSL);
        body_q.push_back(escape_letters[$urandom_range(0, 7)]);
      end else if (pick < 60) begin
        push_unicode(16'($urandom_range(0, 16'h7F)));
      end else if (pick < 68) begin
        push_unicode(16'($urandom_range(16'h80, 16'h7FF)));
      end else if (pick < 76) begin
        push_unicode(16'($urandom_range(16'h800, 16'hFFFF)));
      end else if (pick < 86) begin
        push_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
        push_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (pick < 90) begin
        push_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
      end else if (pick < 93) begin
        push_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (pick < 96) begin
        body_q.push_back(CH_BSL);
        body_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hFF)) : 8'("x"));
      end else if (pick < 98) begin
        body_q.push_back(CH_BSL);
        body_q.push_back(CH_U);
        repeat ($urandom_range(0, 3)) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
        body_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hFF)) : 8'("g"));
      end else begin
        // truncated escape: end the string inside it
        body_q.push_back(CH_BSL);
        if ($urandom_range(0, 1)) begin
          body_q.push_back(CH_U);
          repeat ($urandom_range(0, 3)) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        stop = 1'b1;
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    in_t idle_word;
    int  str_idx;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty string, extreme raw bytes, every escape and surrogate corner.
    send_text("", CLOSE_SEPARATE);
    body_q = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h55, 8'hAA};
    send_body(CLOSE_SEPARATE);
    idle_word = '{has_byte: 1'b0, in_byte: 8'hFF, end_of_string: 1'b0};
    send_word(idle_word);
    send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t", CLOSE_ON_LAST);
    send_text("\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF", CLOSE_ON_LAST);
    send_text("\\uD83D\\uDE00\\udbff\\udfff", CLOSE_ON_LAST);
    send_text("\\uDC00\\uDFFFz", CLOSE_ON_LAST);
    send_text("\\uD800x", CLOSE_ON_LAST);           // held unit, then plain byte
    send_text("\\uD800\\n", CLOSE_ON_LAST);         // held unit, then simple escape
    send_text("\\uD800\\q", CLOSE_ON_LAST);         // held unit, then bad escape
    send_text("\\uD800\\uG", CLOSE_ON_LAST);        // held unit, then bad hex digit
    send_text("\\uD800\\u0041", CLOSE_ON_LAST);     // second escape does not start with D
    send_text("\\uD800\\uDB00\\uDC00", CLOSE_ON_LAST); // second digit below C, then pairs
    send_text("ab\\qcd\\n", CLOSE_ON_LAST);         // bytes after the error are dropped
    send_text("\\u12G4zz", CLOSE_ON_LAST);
    send_text("xy\\", CLOSE_ON_LAST);               // backslash at end
    send_text("\\u12", CLOSE_ON_LAST);              // end inside the digits
    send_text("\\u", CLOSE_SEPARATE);
    send_text("\\uD800", CLOSE_ON_LAST);            // end with a held unit
    send_text("\\uD800", CLOSE_SEPARATE);
    send_text("\\uD800\\", CLOSE_ON_LAST);
    send_text("\\uD800\\uDC", CLOSE_ON_LAST);
    send_text("\\uabcd\\uABCD\\uAbCd", CLOSE_SEPARATE);

    // Random strings until the total word count is reached.
    str_idx = 0;
    while (words_sent < TOTAL_WORDS) begin
      // a stretch with no idling on either side
      tx_quiet = (str_idx >= 4 && str_idx < 8);
      rx_quiet = tx_quiet;
      if (str_idx == 1) begin
        // stall the receiver and keep feeding so the queue fills and in_ready drops
        hold_req = 1'b1;
        body_q.delete();
        repeat (40) body_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        send_body(CLOSE_ON_LAST);
      end
      if (str_idx == 3) wait_drained();
      build_random_body();
      send_body(($urandom_range(0, 4) == 0) ? CLOSE_SEPARATE : CLOSE_ON_LAST);
      str_idx++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d strings; %0d output words checked.",
             words_sent, strings_checked, words_checked);
    $display("Done-word status codes seen, one bit per code: %b", status_seen);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_cmd_fifo.sv
design/jsu_back.sv
design/json_string_unescape_utf8_top.sv
bench/utf8_unescape_checker.sv
bench/tb_json_string_unescape_utf8_top.sv
